[sv/pid_speed_deadband_offset_assert.svh]
// assertion macros for the speed controller checker
// no dependencies; included by the checker file only
`ifndef PID_SPEED_DEADBAND_OFFSET_ASSERT_SVH
`define PID_SPEED_DEADBAND_OFFSET_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PSDO_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PSDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/psdo_pkg.sv]
// shared types, widths and register indexes of the speed controller
// no dependencies
package psdo_pkg;

    // fixed field widths
    localparam int SPEED_WIDTH    = 16;
    localparam int ERR_WIDTH      = SPEED_WIDTH + 1;
    localparam int DIFF_WIDTH     = SPEED_WIDTH + 2;
    localparam int GAIN_WIDTH     = 12;
    localparam int DEADBAND_WIDTH = 10;
    localparam int LEVEL_WIDTH    = 7;
    localparam int DRIVE_WIDTH    = 8;

    // defaults for the module parameters
    localparam int INTEGRAL_WIDTH = 32;
    localparam int GAIN_FRAC_BITS = 10;

    // product widths that do not depend on the integral width
    localparam int PROD_P_WIDTH = GAIN_WIDTH + 1 + ERR_WIDTH;
    localparam int PROD_D_WIDTH = GAIN_WIDTH + 1 + DIFF_WIDTH;

    // configuration port
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = GAIN_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KI_GAIN      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KD_GAIN      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEADBAND     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_OFFSET = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_LIMIT  = 3'd5;

    // register values after reset
    localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RST = 10'd5;
    localparam logic [LEVEL_WIDTH-1:0]    OFFSET_RST   = 7'd6;
    localparam logic [LEVEL_WIDTH-1:0]    LIMIT_RST    = 7'd100;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] target_speed;
        logic signed [SPEED_WIDTH-1:0] measured_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic                          in_deadband;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]     kp_gain;
        logic [GAIN_WIDTH-1:0]     ki_gain;
        logic [GAIN_WIDTH-1:0]     kd_gain;
        logic [DEADBAND_WIDTH-1:0] deadband;
        logic [LEVEL_WIDTH-1:0]    drive_offset;
        logic [LEVEL_WIDTH-1:0]    drive_limit;
    } t_cfg;

endpackage

[sv/psdo_cfg_regs.sv]
// configuration register bank of the speed controller
// depends on psdo_pkg
module psdo_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psdo_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [psdo_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output psdo_pkg::t_cfg                      o_cfg
);

    psdo_pkg::t_cfg r_cfg;
    psdo_pkg::t_cfg n_cfg;

    // register write decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psdo_pkg::CFG_KP_GAIN:
                    n_cfg.kp_gain = i_cfg_data[psdo_pkg::GAIN_WIDTH-1:0];
                psdo_pkg::CFG_KI_GAIN:
                    n_cfg.ki_gain = i_cfg_data[psdo_pkg::GAIN_WIDTH-1:0];
                psdo_pkg::CFG_KD_GAIN:
                    n_cfg.kd_gain = i_cfg_data[psdo_pkg::GAIN_WIDTH-1:0];
                psdo_pkg::CFG_DEADBAND:
                    n_cfg.deadband = i_cfg_data[psdo_pkg::DEADBAND_WIDTH-1:0];
                psdo_pkg::CFG_DRIVE_OFFSET:
                    n_cfg.drive_offset = i_cfg_data[psdo_pkg::LEVEL_WIDTH-1:0];
                psdo_pkg::CFG_DRIVE_LIMIT:
                    n_cfg.drive_limit = i_cfg_data[psdo_pkg::LEVEL_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain      <= '0;
            r_cfg.ki_gain      <= '0;
            r_cfg.kd_gain      <= '0;
            r_cfg.deadband     <= psdo_pkg::DEADBAND_RST;
            r_cfg.drive_offset <= psdo_pkg::OFFSET_RST;
            r_cfg.drive_limit  <= psdo_pkg::LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/psdo_err_stage.sv]
// error stage: error, deadband test, derivative term and integral update
// depends on psdo_pkg; holds the previous error and the integral
module psdo_err_stage #(
    parameter int INTEGRAL_WIDTH = psdo_pkg::INTEGRAL_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  psdo_pkg::t_in_item                     i_item,
    input  psdo_pkg::t_cfg                         i_cfg,
    input  logic                                   i_ready,
    output logic                                   o_ready,
    output logic                                   o_valid,
    output logic signed [psdo_pkg::ERR_WIDTH-1:0]  o_err,
    output logic signed [psdo_pkg::DIFF_WIDTH-1:0] o_diff,
    output logic signed [INTEGRAL_WIDTH-1:0]       o_integral,
    output logic                                   o_in_deadband
);

    localparam int EW    = psdo_pkg::ERR_WIDTH;
    localparam int DW    = psdo_pkg::DIFF_WIDTH;
    localparam int CMP_W = (EW > psdo_pkg::DEADBAND_WIDTH) ? EW : psdo_pkg::DEADBAND_WIDTH;
    localparam int AW    = ((INTEGRAL_WIDTH > EW) ? INTEGRAL_WIDTH : EW) + 1;

    logic                           r_valid;
    logic signed [EW-1:0]           r_prev_err;
    logic signed [INTEGRAL_WIDTH-1:0] r_integral;
    logic signed [DW-1:0]           r_diff;
    logic                           r_hit;

    logic signed [EW-1:0]             n_err;
    logic [EW-1:0]                    err_mag;
    logic                             hit;
    logic signed [DW-1:0]             n_diff;
    logic signed [AW-1:0]             int_sum;
    logic [AW-INTEGRAL_WIDTH:0]       int_top;
    logic signed [INTEGRAL_WIDTH-1:0] int_sat;
    logic signed [INTEGRAL_WIDTH-1:0] n_integral;
    logic                             take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // error and its magnitude against the deadband
    assign n_err   = EW'(i_item.target_speed) - EW'(i_item.measured_speed);
    assign err_mag = n_err[EW-1] ? EW'(-n_err) : EW'(n_err);
    assign hit     = CMP_W'(err_mag) < CMP_W'(i_cfg.deadband);
    assign n_diff  = DW'(n_err) - DW'(r_prev_err);

    // saturating integral add
    assign int_sum = AW'(r_integral) + AW'(n_err);
    assign int_top = int_sum[AW-1:INTEGRAL_WIDTH-1];

    always_comb begin
        if ((&int_top) || !(|int_top)) begin
            int_sat = int_sum[INTEGRAL_WIDTH-1:0];
        end else if (int_sum[AW-1]) begin
            int_sat = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
        end else begin
            int_sat = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end
    end

    // integral moves only outside the deadband, zero ki clears it
    always_comb begin
        n_integral = r_integral;
        if (take && !hit) begin
            if (i_cfg.ki_gain == '0) begin
                n_integral = '0;
            end else begin
                n_integral = int_sat;
            end
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integral <= '0;
        end else begin
            r_integral <= n_integral;
            if (take) begin
                r_prev_err <= n_err;
            end
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_diff <= n_diff;
            r_hit  <= hit;
        end
    end

    // the state registers already hold this transaction's error and integral
    assign o_valid       = r_valid;
    assign o_err         = r_prev_err;
    assign o_diff        = r_diff;
    assign o_integral    = r_integral;
    assign o_in_deadband = r_hit;

endmodule

[sv/psdo_mac_stage.sv]
// product stage: the three gain multiplications, one register behind each
// depends on psdo_pkg
module psdo_mac_stage #(
    parameter int INTEGRAL_WIDTH = psdo_pkg::INTEGRAL_WIDTH,
    localparam int PROD_I_WIDTH  = psdo_pkg::GAIN_WIDTH + 1 + INTEGRAL_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [psdo_pkg::ERR_WIDTH-1:0]    i_err,
    input  logic signed [psdo_pkg::DIFF_WIDTH-1:0]   i_diff,
    input  logic signed [INTEGRAL_WIDTH-1:0]         i_integral,
    input  logic                                     i_in_deadband,
    input  psdo_pkg::t_cfg                           i_cfg,
    input  logic                                     i_ready,
    output logic                                     o_ready,
    output logic                                     o_valid,
    output logic signed [psdo_pkg::PROD_P_WIDTH-1:0] o_prod_p,
    output logic signed [PROD_I_WIDTH-1:0]           o_prod_i,
    output logic signed [psdo_pkg::PROD_D_WIDTH-1:0] o_prod_d,
    output logic                                     o_in_deadband
);

    localparam int SGW = psdo_pkg::GAIN_WIDTH + 1;

    logic                                     r_valid;
    logic signed [psdo_pkg::PROD_P_WIDTH-1:0] r_prod_p;
    logic signed [PROD_I_WIDTH-1:0]           r_prod_i;
    logic signed [psdo_pkg::PROD_D_WIDTH-1:0] r_prod_d;
    logic                                     r_hit;

    logic signed [SGW-1:0]                    kp_s;
    logic signed [SGW-1:0]                    ki_s;
    logic signed [SGW-1:0]                    kd_s;
    logic signed [psdo_pkg::PROD_P_WIDTH-1:0] n_prod_p;
    logic signed [PROD_I_WIDTH-1:0]           n_prod_i;
    logic signed [psdo_pkg::PROD_D_WIDTH-1:0] n_prod_d;
    logic                                     take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // unsigned gains as non-negative signed operands
    assign kp_s = signed'({1'b0, i_cfg.kp_gain});
    assign ki_s = signed'({1'b0, i_cfg.ki_gain});
    assign kd_s = signed'({1'b0, i_cfg.kd_gain});

    assign n_prod_p = psdo_pkg::PROD_P_WIDTH'(kp_s) * psdo_pkg::PROD_P_WIDTH'(i_err);
    assign n_prod_i = PROD_I_WIDTH'(ki_s) * PROD_I_WIDTH'(i_integral);
    assign n_prod_d = psdo_pkg::PROD_D_WIDTH'(kd_s) * psdo_pkg::PROD_D_WIDTH'(i_diff);

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // product registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_hit    <= i_in_deadband;
        end
    end

    assign o_valid       = r_valid;
    assign o_prod_p      = r_prod_p;
    assign o_prod_i      = r_prod_i;
    assign o_prod_d      = r_prod_d;
    assign o_in_deadband = r_hit;

endmodule

[sv/psdo_out_stage.sv]
// output stage: sum of terms, offset away from zero, clamp and truncation
// depends on psdo_pkg; owns the result register seen on the output channel
module psdo_out_stage #(
    parameter int INTEGRAL_WIDTH = psdo_pkg::INTEGRAL_WIDTH,
    parameter int GAIN_FRAC_BITS = psdo_pkg::GAIN_FRAC_BITS,
    localparam int PROD_I_WIDTH  = psdo_pkg::GAIN_WIDTH + 1 + INTEGRAL_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [psdo_pkg::PROD_P_WIDTH-1:0] i_prod_p,
    input  logic signed [PROD_I_WIDTH-1:0]           i_prod_i,
    input  logic signed [psdo_pkg::PROD_D_WIDTH-1:0] i_prod_d,
    input  logic                                     i_in_deadband,
    input  psdo_pkg::t_cfg                           i_cfg,
    input  logic                                     i_stall,
    output logic                                     o_ready,
    output logic                                     o_valid,
    output psdo_pkg::t_out_item                      o_result
);

    localparam int MAXP  = (PROD_I_WIDTH > psdo_pkg::PROD_D_WIDTH) ?
                           PROD_I_WIDTH : psdo_pkg::PROD_D_WIDTH;
    localparam int SUM_W = MAXP + 2;
    localparam int TV_W  = SUM_W + 1;
    localparam int DRW   = psdo_pkg::DRIVE_WIDTH;
    localparam int LVW   = psdo_pkg::LEVEL_WIDTH;

    logic                r_valid;
    psdo_pkg::t_out_item r_result;

    logic signed [SUM_W-1:0] acc;
    logic                    acc_neg;
    logic                    acc_zero;
    logic [SUM_W-1:0]        acc_mag;
    logic [TV_W-1:0]         pushed;
    logic [TV_W-1:0]         lim;
    logic [TV_W-1:0]         clamped;
    logic [LVW-1:0]          level;
    logic signed [DRW-1:0]   level_s;
    psdo_pkg::t_out_item     n_result;
    logic                    take;

    assign o_ready = !r_valid || !i_stall;
    assign take    = i_valid && o_ready;

    // controller sum
    assign acc = SUM_W'(i_prod_p) + SUM_W'(i_prod_i) + SUM_W'(i_prod_d);
    assign acc_neg  = acc[SUM_W-1];
    assign acc_zero = (acc == '0);
    assign acc_mag  = acc_neg ? SUM_W'(-acc) : SUM_W'(acc);

    // offset away from zero, clamp to the limit, drop the fraction
    assign pushed  = TV_W'(acc_mag) + (TV_W'(i_cfg.drive_offset) << GAIN_FRAC_BITS);
    assign lim     = TV_W'(i_cfg.drive_limit) << GAIN_FRAC_BITS;
    assign clamped = (pushed > lim) ? lim : pushed;
    assign level   = clamped[GAIN_FRAC_BITS +: LVW];
    assign level_s = signed'(DRW'(level));

    always_comb begin
        n_result.in_deadband = i_in_deadband;
        if (i_in_deadband || acc_zero) begin
            n_result.drive = '0;
        end else if (acc_neg) begin
            n_result.drive = -level_s;
        end else begin
            n_result.drive = level_s;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[sv/pid_speed_deadband_offset.sv]
// top level of the positional speed controller with deadband and drive offset
// depends on psdo_pkg, psdo_cfg_regs, psdo_err_stage, psdo_mac_stage, psdo_out_stage
//
// usage
//   input channel: i_valid / o_stall with i_item carrying target and measured
//   speed; a transaction is taken on a rising edge with i_valid high and
//   o_stall low. output channel: o_valid / i_stall with o_result carrying the
//   signed drive and the deadband flag, one result per input transaction.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx on the
//   edge; indexes past the drive limit are ignored. write only while idle.
// stages and throughput
//   four register stages: input register, error stage, product stage and
//   result register. a taken transaction passes through them in that order
//   to o_valid. one transaction per cycle is sustained while i_stall is low;
//   the product stage holds the three gain multipliers.
// reset and stall
//   synchronous active-low reset empties the pipeline, clears the previous
//   error and the integral and loads the register defaults. while i_stall is
//   high the result register holds; empty stages upstream keep filling, and
//   o_stall rises only once every stage holds a transaction.
module pid_speed_deadband_offset #(
    parameter int INTEGRAL_WIDTH = psdo_pkg::INTEGRAL_WIDTH,
    parameter int GAIN_FRAC_BITS = psdo_pkg::GAIN_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  psdo_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output psdo_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_we,
    input  logic [psdo_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [psdo_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int PROD_I_WIDTH = psdo_pkg::GAIN_WIDTH + 1 + INTEGRAL_WIDTH;

    psdo_pkg::t_cfg cfg;

    logic               r_in_valid;
    psdo_pkg::t_in_item r_in_item;
    logic               in_ready;
    logic               take;

    logic                                   err_ready;
    logic                                   err_valid;
    logic signed [psdo_pkg::ERR_WIDTH-1:0]  err_err;
    logic signed [psdo_pkg::DIFF_WIDTH-1:0] err_diff;
    logic signed [INTEGRAL_WIDTH-1:0]       err_integral;
    logic                                   err_hit;

    logic                                     mac_ready;
    logic                                     mac_valid;
    logic signed [psdo_pkg::PROD_P_WIDTH-1:0] mac_prod_p;
    logic signed [PROD_I_WIDTH-1:0]           mac_prod_i;
    logic signed [psdo_pkg::PROD_D_WIDTH-1:0] mac_prod_d;
    logic                                     mac_hit;

    logic out_ready;

    psdo_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    assign in_ready = !r_in_valid || err_ready;
    assign o_stall  = !in_ready;
    assign take     = i_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_item <= i_item;
        end
    end

    psdo_err_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_err (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_item        (r_in_item),
        .i_cfg         (cfg),
        .i_ready       (mac_ready),
        .o_ready       (err_ready),
        .o_valid       (err_valid),
        .o_err         (err_err),
        .o_diff        (err_diff),
        .o_integral    (err_integral),
        .o_in_deadband (err_hit)
    );

    psdo_mac_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (err_valid),
        .i_err         (err_err),
        .i_diff        (err_diff),
        .i_integral    (err_integral),
        .i_in_deadband (err_hit),
        .i_cfg         (cfg),
        .i_ready       (out_ready),
        .o_ready       (mac_ready),
        .o_valid       (mac_valid),
        .o_prod_p      (mac_prod_p),
        .o_prod_i      (mac_prod_i),
        .o_prod_d      (mac_prod_d),
        .o_in_deadband (mac_hit)
    );

    psdo_out_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mac_valid),
        .i_prod_p      (mac_prod_p),
        .i_prod_i      (mac_prod_i),
        .i_prod_d      (mac_prod_d),
        .i_in_deadband (mac_hit),
        .i_cfg         (cfg),
        .i_stall       (i_stall),
        .o_ready       (out_ready),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule

[sv/psdo_checker.sv]
// port-level checker for the speed controller, bound to the top level
// depends on psdo_pkg and pid_speed_deadband_offset_assert.svh
`include "pid_speed_deadband_offset_assert.svh"

module psdo_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input psdo_pkg::t_out_item o_result
);

    localparam logic signed [psdo_pkg::DRIVE_WIDTH-1:0] DRIVE_MOST_NEG =
        {1'b1, {(psdo_pkg::DRIVE_WIDTH-1){1'b0}}};

    // a deadband transaction never drives the motor
    `PSDO_ASSERT_HOLDS(a_deadband_zero, i_clk, i_rst_n, o_valid && o_result.in_deadband, o_result.drive == '0, "drive nonzero inside the deadband")

    // the clamp keeps the drive symmetric
    `PSDO_ASSERT_HOLDS(a_drive_range, i_clk, i_rst_n, o_valid, o_result.drive != DRIVE_MOST_NEG, "drive outside the symmetric range")

    // input back-pressure only when the whole pipeline is full and blocked
    `PSDO_ASSERT_HOLDS(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while the output is free")

    // a stalled result holds
    `PSDO_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result), "stalled result changed")

endmodule

bind pid_speed_deadband_offset psdo_checker u_psdo_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
